@@ sv/gcd_pkg.sv @@
// Shared constants, types and lookup functions of the grid code decoder.
package gcd_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int PAIRS      = (NUM_DIGITS + 1) / 2;
  localparam int TOTAL_POS  = 2 * PAIRS;

  localparam int IDX_W   = 25;
  localparam int CNT_W   = 4;
  localparam int STEP_W  = 32;
  localparam int PAIR_W  = 3;
  localparam int LAT_W   = 32;
  localparam int LON_W   = 33;
  localparam int PROD_W  = IDX_W + STEP_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int FRAC_SH = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LAT_STEP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LON_STEP = 1'd1;

  localparam logic [STEP_W-1:0] LAT_STEP_RESET = 32'd11544872;
  localparam logic [STEP_W-1:0] LON_STEP_RESET = 32'd23089744;

  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Offsets of 90 and 180 degrees in units of 2^-40 degree.
  localparam logic [DIFF_W-1:0] LAT_OFFSET = DIFF_W'(90) << 40;
  localparam logic [DIFF_W-1:0] LON_OFFSET = DIFF_W'(180) << 40;
  localparam logic [DIFF_W-1:0] TRUNC_BIAS = DIFF_W'((1 << FRAC_SH) - 1);

  localparam int NUM_SYMS = 28;
  localparam logic [7:0] SYM_SET [NUM_SYMS] = '{
    8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h42, 8'h43, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h56, 8'h57, 8'h58, 8'h5A
  };

  typedef struct packed {
    logic       valid;
    logic [4:0] value;
  } sym_t;

  // Lower case letters fold to upper case; every digit symbol is a letter or
  // a numeral, so folding never makes a non-letter valid.
  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t       res;
    logic [7:0] u;
    res = '0;
    u   = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_OFFSET : c;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (u == SYM_SET[k]) begin
        res.valid = 1'b1;
        res.value = 5'(k);
      end
    end
    return res;
  endfunction

  // Place value 28^(PAIRS-1-pair) of a digit, wrapped to the index width.
  function automatic logic [IDX_W-1:0] pair_weight(input logic [PAIR_W-1:0] pair);
    logic [IDX_W-1:0] w;
    w = IDX_W'(1);
    for (int k = 1; k < PAIRS; k++) begin
      if (k > int'(pair)) begin
        w = IDX_W'(w * IDX_W'(28));
      end
    end
    return w;
  endfunction

endpackage

@@ sv/gcd_in_if.sv @@
// Request channel carrying one code character per transfer.
interface gcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

@@ sv/gcd_out_if.sv @@
// Result channel carrying one decoded grid position per transfer.
interface gcd_out_if;
  logic               valid;
  logic               ready;
  logic        [24:0] lat_index;
  logic        [24:0] lon_index;
  logic signed [31:0] lat_degrees;
  logic signed [32:0] lon_degrees;
  logic               bad_code;

  modport source (output valid, output lat_index, output lon_index, output lat_degrees,
                  output lon_degrees, output bad_code, input ready);
  modport sink   (input valid, input lat_index, input lon_index, input lat_degrees,
                  input lon_degrees, input bad_code, output ready);
endinterface

@@ sv/grid_code_decoder_core.sv @@
// Grid code decoder: character stream in, latitude/longitude indices and degrees out.
//
// in_chan takes one code character per request, with last_char set on the final
// one. Dashes are skipped, digit symbols accumulate into the two axis indices
// as they arrive, and the final character closes the code. out_chan then
// carries one result per code: both indices, both positions in 2^-24 degree
// units, and bad_code (all other fields zero when it is set).
// Throughput is one character per cycle while in_chan is not stalled. A result
// passes from the final character of its code through the decode stage, the
// 25x32 step multiply stage, then the offset/truncate stage into the
// output register. Each stage moves forward whenever the one after it is empty
// or draining, so characters keep flowing while a result waits on out_chan;
// in_chan stalls only when all three stages hold results and out_chan is not ready.
// cfg_we writes lat_step (index 0) or lon_step (index 1) at the clock edge.
// Reset (rst_n low, synchronous) empties the pipeline, clears the partial
// code and restores the default steps.
module grid_code_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gcd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  gcd_in_if.sink                              in_chan,
  gcd_out_if.source                           out_chan
);

  logic [gcd_pkg::STEP_W-1:0] lat_step_r;
  logic [gcd_pkg::STEP_W-1:0] lon_step_r;

  // Partial code state.
  logic [gcd_pkg::CNT_W-1:0] digits_r, digits_nxt;
  logic [gcd_pkg::IDX_W-1:0] lat_acc_r, lat_acc_nxt;
  logic [gcd_pkg::IDX_W-1:0] lon_acc_r, lon_acc_nxt;
  logic                      err_r, err_nxt;

  // Stage 1: finished indices.
  logic                      s1_valid_r;
  logic [gcd_pkg::IDX_W-1:0] s1_lat_r, s1_lon_r;
  logic                      s1_bad_r;
  logic                      s1_bad_nxt;

  // Stage 2: products.
  logic                       s2_valid_r;
  logic [gcd_pkg::IDX_W-1:0]  s2_lat_r, s2_lon_r;
  logic                       s2_bad_r;
  logic [gcd_pkg::PROD_W-1:0] s2_lat_prod_r, s2_lon_prod_r;

  // Stage 3: output register.
  logic                       s3_valid_r;
  logic [gcd_pkg::IDX_W-1:0]  s3_lat_r, s3_lon_r;
  logic                       s3_bad_r;
  logic [gcd_pkg::LAT_W-1:0]  s3_lat_deg_r, s3_lat_deg_nxt;
  logic [gcd_pkg::LON_W-1:0]  s3_lon_deg_r, s3_lon_deg_nxt;

  logic adv3, adv2, adv1;
  logic in_fire, close_code, take_char;
  gcd_pkg::sym_t sym;
  logic [gcd_pkg::IDX_W-1:0] add_val;

  logic [gcd_pkg::DIFF_W-1:0] lat_diff, lat_diff_b, lat_sel;
  logic [gcd_pkg::DIFF_W-1:0] lon_diff, lon_diff_b, lon_sel;

  assign adv3 = !s3_valid_r || out_chan.ready;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;

  assign in_chan.ready = adv1;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign close_code    = in_fire && in_chan.last_char;

  // Character decode and accumulate.
  always_comb begin
    sym         = gcd_pkg::sym_lookup(in_chan.code_char);
    add_val     = gcd_pkg::IDX_W'(sym.value * gcd_pkg::pair_weight(
                    gcd_pkg::PAIR_W'(digits_r >> 1)));
    take_char   = !err_r && (digits_r < gcd_pkg::CNT_W'(gcd_pkg::TOTAL_POS)) &&
                  (in_chan.code_char != gcd_pkg::CHAR_DASH);
    digits_nxt  = digits_r;
    lat_acc_nxt = lat_acc_r;
    lon_acc_nxt = lon_acc_r;
    err_nxt     = err_r;
    if (take_char) begin
      if (!sym.valid) begin
        err_nxt = 1'b1;
      end else begin
        if (!digits_r[0]) begin
          lat_acc_nxt = lat_acc_r + add_val;
        end else begin
          lon_acc_nxt = lon_acc_r + add_val;
        end
        digits_nxt = digits_r + gcd_pkg::CNT_W'(1);
      end
    end
    s1_bad_nxt = err_nxt ||
                 (digits_nxt[0] && digits_nxt < gcd_pkg::CNT_W'(gcd_pkg::TOTAL_POS - 1));
  end

  // Subtract the offset, then truncate toward zero: negative differences take
  // a bias of 2^16-1 before the shift.
  always_comb begin
    lat_diff   = {1'b0, s2_lat_prod_r} - gcd_pkg::LAT_OFFSET;
    lat_diff_b = {1'b0, s2_lat_prod_r} - (gcd_pkg::LAT_OFFSET - gcd_pkg::TRUNC_BIAS);
    lon_diff   = {1'b0, s2_lon_prod_r} - gcd_pkg::LON_OFFSET;
    lon_diff_b = {1'b0, s2_lon_prod_r} - (gcd_pkg::LON_OFFSET - gcd_pkg::TRUNC_BIAS);
    lat_sel    = lat_diff[gcd_pkg::DIFF_W-1] ? lat_diff_b : lat_diff;
    lon_sel    = lon_diff[gcd_pkg::DIFF_W-1] ? lon_diff_b : lon_diff;
    s3_lat_deg_nxt = s2_bad_r ? '0 :
                     lat_sel[gcd_pkg::FRAC_SH +: gcd_pkg::LAT_W];
    s3_lon_deg_nxt = s2_bad_r ? '0 :
                     lon_sel[gcd_pkg::FRAC_SH +: gcd_pkg::LON_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_step_r <= gcd_pkg::LAT_STEP_RESET;
      lon_step_r <= gcd_pkg::LON_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gcd_pkg::REG_LAT_STEP: lat_step_r <= cfg_wdata;
        gcd_pkg::REG_LON_STEP: lon_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r  <= '0;
      lat_acc_r <= '0;
      lon_acc_r <= '0;
      err_r     <= 1'b0;
    end else if (in_fire) begin
      if (in_chan.last_char) begin
        digits_r  <= '0;
        lat_acc_r <= '0;
        lon_acc_r <= '0;
        err_r     <= 1'b0;
      end else begin
        digits_r  <= digits_nxt;
        lat_acc_r <= lat_acc_nxt;
        lon_acc_r <= lon_acc_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= close_code;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close_code) begin
      s1_bad_r <= s1_bad_nxt;
      s1_lat_r <= s1_bad_nxt ? '0 : lat_acc_nxt;
      s1_lon_r <= s1_bad_nxt ? '0 : lon_acc_nxt;
    end
    if (adv2 && s1_valid_r) begin
      s2_bad_r      <= s1_bad_r;
      s2_lat_r      <= s1_lat_r;
      s2_lon_r      <= s1_lon_r;
      s2_lat_prod_r <= gcd_pkg::PROD_W'(s1_lat_r) * gcd_pkg::PROD_W'(lat_step_r);
      s2_lon_prod_r <= gcd_pkg::PROD_W'(s1_lon_r) * gcd_pkg::PROD_W'(lon_step_r);
    end
    if (adv3 && s2_valid_r) begin
      s3_bad_r     <= s2_bad_r;
      s3_lat_r     <= s2_lat_r;
      s3_lon_r     <= s2_lon_r;
      s3_lat_deg_r <= s3_lat_deg_nxt;
      s3_lon_deg_r <= s3_lon_deg_nxt;
    end
  end

  assign out_chan.valid       = s3_valid_r;
  assign out_chan.lat_index   = s3_lat_r;
  assign out_chan.lon_index   = s3_lon_r;
  assign out_chan.lat_degrees = $signed(s3_lat_deg_r);
  assign out_chan.lon_degrees = $signed(s3_lon_deg_r);
  assign out_chan.bad_code    = s3_bad_r;

endmodule
